@@ hdl/sptq_pkg.sv @@
// Shared types and constants for the strict priority task queue block.
// Used by sptq_ctrl, strict_priority_task_queues, sptq_checker and the testbench; no dependencies.
`default_nettype none

package sptq_pkg;

    // Field widths of one request and one result
    localparam int CMD_W       = 1;
    localparam int LEVEL_W     = 2;
    localparam int HANDLE_BITS = 16;
    localparam int STATUS_W    = 2;

    // Stream data widths, rounded up to whole bytes
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 24;

    // Defaults for the top level parameters
    localparam int LEVELS_DEF      = 4;
    localparam int QUEUE_DEPTH_DEF = 16;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_ENQ = 1'b0;
    localparam logic [CMD_W-1:0] CMD_DEQ = 1'b1;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_NULL  = 2'd1,
        ST_FULL  = 2'd2,
        ST_EMPTY = 2'd3
    } t_status;

    // Outcome of one request, handed from the controller to the result path
    typedef struct packed {
        t_status              status;
        logic [LEVEL_W-1:0]   level;
        logic                 take_data;
    } t_op;

endpackage

`default_nettype wire

@@ hdl/sptq_ram.sv @@
// Generic single write port, single read port RAM with registered read.
// No dependencies.
`default_nettype none

module sptq_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port, holds while not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ hdl/sptq_ctrl.sv @@
// Per-level head, tail and fill count registers plus the priority select.
// Decides each request and drives the queue RAM ports; uses sptq_pkg.
`default_nettype none

module sptq_ctrl
    import sptq_pkg::*;
#(
    parameter int LEVELS      = LEVELS_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    localparam int LW  = $clog2(LEVELS),
    localparam int PW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1,
    localparam int AW  = LW + PW
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_accept,
    input  wire logic [CMD_W-1:0]       i_cmd,
    input  wire logic [LEVEL_W-1:0]     i_level,
    input  wire logic [HANDLE_BITS-1:0] i_handle,
    output logic                        o_we,
    output logic [AW-1:0]               o_waddr,
    output logic                        o_re,
    output logic [AW-1:0]               o_raddr,
    output t_op                         o_op
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST  = PW'(QUEUE_DEPTH - 1);
    localparam logic [CW-1:0] COUNT_MAX = CW'(QUEUE_DEPTH);

    logic [PW-1:0] r_head  [LEVELS];
    logic [PW-1:0] r_tail  [LEVELS];
    logic [CW-1:0] r_count [LEVELS];

    logic          is_enq;
    logic [LW-1:0] enq_lvl;
    logic [LW-1:0] deq_lvl;
    logic          any_ready;
    logic          enq_ok;
    logic          deq_ok;
    logic [PW-1:0] tail_sel;
    logic [PW-1:0] head_sel;
    logic [CW-1:0] count_enq;

    // Enqueue level saturates at the top level
    always_comb begin
        if (32'(i_level) >= LEVELS) begin
            enq_lvl = LW'(LEVELS - 1);
        end else begin
            enq_lvl = i_level[LW-1:0];
        end
    end

    // Highest non-empty level wins
    always_comb begin
        deq_lvl   = '0;
        any_ready = 1'b0;
        for (int l = 0; l < LEVELS; l++) begin
            if (r_count[l] != '0) begin
                deq_lvl   = LW'(l);
                any_ready = 1'b1;
            end
        end
    end

    assign tail_sel  = r_tail[enq_lvl];
    assign count_enq = r_count[enq_lvl];
    assign head_sel  = r_head[deq_lvl];

    // Decision and result status
    always_comb begin
        is_enq         = (i_cmd == CMD_ENQ);
        enq_ok         = 1'b0;
        deq_ok         = 1'b0;
        o_op.level     = '0;
        o_op.take_data = 1'b0;
        if (is_enq) begin
            if (i_handle == '0) begin
                o_op.status = ST_NULL;
            end else if (count_enq == COUNT_MAX) begin
                o_op.status = ST_FULL;
            end else begin
                o_op.status = ST_OK;
                enq_ok      = 1'b1;
            end
        end else if (any_ready) begin
            o_op.status    = ST_OK;
            o_op.level     = LEVEL_W'(deq_lvl);
            o_op.take_data = 1'b1;
            deq_ok         = 1'b1;
        end else begin
            o_op.status = ST_EMPTY;
        end
    end

    // RAM ports: queue entry is addressed by level and slot
    assign o_we    = i_accept && enq_ok;
    assign o_waddr = {enq_lvl, tail_sel};
    assign o_re    = i_accept && deq_ok;
    assign o_raddr = {deq_lvl, head_sel};

    // Pointer and count update, one lane per level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int l = 0; l < LEVELS; l++) begin
                r_head[l]  <= '0;
                r_tail[l]  <= '0;
                r_count[l] <= '0;
            end
        end else if (i_accept) begin
            for (int l = 0; l < LEVELS; l++) begin
                if (enq_ok && (enq_lvl == LW'(l))) begin
                    r_tail[l]  <= (r_tail[l] == PTR_LAST) ? '0 : r_tail[l] + 1'b1;
                    r_count[l] <= r_count[l] + 1'b1;
                end
                if (deq_ok && (deq_lvl == LW'(l))) begin
                    r_head[l]  <= (r_head[l] == PTR_LAST) ? '0 : r_head[l] + 1'b1;
                    r_count[l] <= r_count[l] - 1'b1;
                end
            end
        end
    end

endmodule

`default_nettype wire

@@ hdl/strict_priority_task_queues.sv @@
// Top level of the strict priority task queue block.
// Instantiates sptq_ctrl and sptq_ram; uses sptq_pkg.
//
// One FIFO of task handles per priority level, QUEUE_DEPTH entries each,
// held in a single RAM addressed by level and slot. A request either
// enqueues a non-zero handle at its level (status full when that level is
// at capacity, null for a zero handle) or dequeues the head of the highest
// non-empty level (status empty when none is). Every request gives exactly
// one result, in order. The block takes one request per clock while m_tready
// keeps the output moving; each result passes through the stage one register,
// alongside the registered RAM read, and then the output register. LEVELS may
// range from 2 to 4 (the level field is two bits wide), QUEUE_DEPTH from 2 to
// 1024. No clearing pass is needed after reset.
`default_nettype none

module strict_priority_task_queues
    import sptq_pkg::*;
#(
    parameter int LEVELS      = LEVELS_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // cmd[0], level[2:1], task_handle[18:3], zero pad above
    input  wire logic [IN_DATA_W-1:0]  s_tdata,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // status[1:0], out_handle[17:2], out_level[19:18], zero pad above
    output logic      [OUT_DATA_W-1:0] m_tdata
);

    localparam int LW = $clog2(LEVELS);
    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int AW = LW + PW;
    localparam int PAD_W = OUT_DATA_W - STATUS_W - HANDLE_BITS - LEVEL_W;

    logic                   accept;
    logic                   s1_adv;
    logic                   we;
    logic                   re;
    logic [AW-1:0]          waddr;
    logic [AW-1:0]          raddr;
    logic [HANDLE_BITS-1:0] rdata;
    logic [HANDLE_BITS-1:0] handle_in;
    logic [HANDLE_BITS-1:0] handle_out;
    t_op                    op;

    logic                   r_s1_valid;
    t_op                    r_s1_op;
    logic                   r_out_valid;
    logic [OUT_DATA_W-1:0]  r_out_data;

    assign handle_in = s_tdata[CMD_W+LEVEL_W +: HANDLE_BITS];

    // Handshake: stage one moves on when the output register is free
    assign s1_adv   = r_s1_valid && (!r_out_valid || m_tready);
    assign s_tready = !r_s1_valid || s1_adv;
    assign accept   = s_tvalid && s_tready;

    sptq_ctrl #(
        .LEVELS      (LEVELS),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_cmd    (s_tdata[0 +: CMD_W]),
        .i_level  (s_tdata[CMD_W +: LEVEL_W]),
        .i_handle (handle_in),
        .o_we     (we),
        .o_waddr  (waddr),
        .o_re     (re),
        .o_raddr  (raddr),
        .o_op     (op)
    );

    sptq_ram #(
        .WIDTH (HANDLE_BITS),
        .DEPTH (LEVELS << PW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (handle_in),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // Stage one: request outcome, waiting on the RAM read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_op <= op;
        end
    end

    // Handle is returned only by a successful dequeue
    assign handle_out = r_s1_op.take_data ? rdata : '0;

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_data <= {{PAD_W{1'b0}}, r_s1_op.level, handle_out, r_s1_op.status};
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = r_out_data;

endmodule

`default_nettype wire

@@ dv/sptq_checker.sv @@
// Checker for the strict priority task queue block: watches both stream ports,
// predicts each result from its own copy of the per-level FIFOs and compares.
// Depends on sptq_pkg for field widths, command and status codes.

module sptq_checker
    import sptq_pkg::*;
#(
    parameter int LEVELS      = LEVELS_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_s_tvalid,
    input  wire logic                  i_s_tready,
    // cmd[0], level[2:1], task_handle[18:3], zero pad above
    input  wire logic [IN_DATA_W-1:0]  i_s_tdata,
    input  wire logic                  i_m_tvalid,
    input  wire logic                  i_m_tready,
    // status[1:0], out_handle[17:2], out_level[19:18], zero pad above
    input  wire logic [OUT_DATA_W-1:0] i_m_tdata,
    output int                         o_fail_count,
    output int                         o_awaited
);

    // Bit positions within the request and result words
    localparam int REQ_LEVEL_LO  = CMD_W;
    localparam int REQ_HANDLE_LO = CMD_W + LEVEL_W;
    localparam int RES_HANDLE_LO = STATUS_W;
    localparam int RES_LEVEL_LO  = STATUS_W + HANDLE_BITS;

    typedef struct packed {
        t_status                status;
        logic [HANDLE_BITS-1:0] handle;
        logic [LEVEL_W-1:0]     level;
    } t_outcome;

    // Shadow of the per-level FIFOs
    logic [HANDLE_BITS-1:0] slot_store [LEVELS][QUEUE_DEPTH];
    int unsigned            rd_ptr     [LEVELS];
    int unsigned            wr_ptr     [LEVELS];
    int unsigned            occupancy  [LEVELS];

    t_outcome outcomes_due[$];
    int       fails = 0;

    // Apply one request to the shadow FIFOs and return the result it gives
    function automatic t_outcome serve_request(logic cmd, logic [LEVEL_W-1:0] lvl_in,
                                               logic [HANDLE_BITS-1:0] handle);
        t_outcome res;
        int       lvl;
        int       l;
        res.status = ST_OK;
        res.handle = '0;
        res.level  = '0;
        if (cmd == CMD_ENQ) begin
            // levels beyond the configured count fold onto the top one
            lvl = (int'(lvl_in) >= LEVELS) ? LEVELS - 1 : int'(lvl_in);
            if (handle == '0) begin
                res.status = ST_NULL;
            end else if (occupancy[lvl] >= QUEUE_DEPTH) begin
                res.status = ST_FULL;
            end else begin
                slot_store[lvl][wr_ptr[lvl]] = handle;
                wr_ptr[lvl]    = (wr_ptr[lvl] + 1) % QUEUE_DEPTH;
                occupancy[lvl] = occupancy[lvl] + 1;
            end
        end else begin
            // highest non-empty level wins
            res.status = ST_EMPTY;
            for (l = LEVELS - 1; l >= 0; l--) begin
                if (res.status == ST_EMPTY && occupancy[l] != 0) begin
                    res.handle   = slot_store[l][rd_ptr[l]];
                    res.level    = LEVEL_W'(l);
                    res.status   = ST_OK;
                    rd_ptr[l]    = (rd_ptr[l] + 1) % QUEUE_DEPTH;
                    occupancy[l] = occupancy[l] - 1;
                end
            end
        end
        return res;
    endfunction

    // Results are checked before the request of the same edge is predicted
    always @(posedge i_clk) begin
        t_outcome want;
        t_outcome got;
        t_outcome fresh;
        int       l;
        if (!i_rst_n) begin
            outcomes_due.delete();
            for (l = 0; l < LEVELS; l++) begin
                rd_ptr[l]    = 0;
                wr_ptr[l]    = 0;
                occupancy[l] = 0;
            end
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                got.status = t_status'(i_m_tdata[STATUS_W-1:0]);
                got.handle = i_m_tdata[RES_HANDLE_LO +: HANDLE_BITS];
                got.level  = i_m_tdata[RES_LEVEL_LO +: LEVEL_W];
                if (outcomes_due.size() == 0) begin
                    fails++;
                    $display({"%0t: unexpected result, expected none, ",
                              "actual status %s handle %0h level %0d"},
                             $time, got.status.name(), got.handle, got.level);
                end else begin
                    want = outcomes_due[0];
                    outcomes_due.delete(0);
                    if (got.status != want.status) begin
                        fails++;
                        $display("%0t: status mismatch, expected %s, actual %s",
                                 $time, want.status.name(), got.status.name());
                    end
                    if (got.handle != want.handle) begin
                        fails++;
                        $display("%0t: handle mismatch, expected %0h, actual %0h",
                                 $time, want.handle, got.handle);
                    end
                    if (got.level != want.level) begin
                        fails++;
                        $display("%0t: level mismatch, expected %0d, actual %0d",
                                 $time, want.level, got.level);
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                fresh = serve_request(i_s_tdata[0],
                                      i_s_tdata[REQ_LEVEL_LO +: LEVEL_W],
                                      i_s_tdata[REQ_HANDLE_LO +: HANDLE_BITS]);
                outcomes_due.insert(outcomes_due.size(), fresh);
            end
        end
        o_awaited    = outcomes_due.size();
        o_fail_count = fails;
    end

endmodule

@@ dv/strict_priority_task_queues_tb.sv @@
// Testbench top for the strict priority task queue block: drives requests,
// stalls the result port and gives the verdict.
// Depends on sptq_pkg, strict_priority_task_queues and sptq_checker.

module strict_priority_task_queues_tb;
    import sptq_pkg::*;

    localparam int RANDOM_ITEMS = 1200;
    localparam int HOLD_CYCLES  = 200;
    localparam int CLK_HALF     = 6;
    localparam int LIMIT_CYCLES = 200000;

    typedef enum int {RX_FREE, RX_COIN, RX_SPARSE, RX_CADENCE} t_rx_mode;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    int                    fail_count;
    int                    awaited;

    int   burst_left = 1;
    logic hold_ask   = 1'b0;

    strict_priority_task_queues #(
        .LEVELS      (LEVELS_DEF),
        .QUEUE_DEPTH (QUEUE_DEPTH_DEF)
    ) u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    sptq_checker #(
        .LEVELS      (LEVELS_DEF),
        .QUEUE_DEPTH (QUEUE_DEPTH_DEF)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .o_fail_count (fail_count),
        .o_awaited    (awaited)
    );

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Run limit, far above the slowest legal run
    initial begin
        #(2 * CLK_HALF * LIMIT_CYCLES);
        $display("== FAIL ==");
        $finish;
    end

    // Offer one request and wait for it to be taken; bursts end in a random gap or none
    task automatic send_request(input logic cmd, input logic [LEVEL_W-1:0] lvl,
                                input logic [HANDLE_BITS-1:0] handle);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= {{(IN_DATA_W - CMD_W - LEVEL_W - HANDLE_BITS){1'b0}}, handle, lvl, cmd};
        do @(posedge i_clk); while (!s_tready);
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    // Stop offering until every outstanding result has come back
    task automatic wait_all_results();
        s_tvalid <= 1'b0;
        do @(posedge i_clk); while (awaited != 0);
    endtask

    // Result port stalls: windows of differing patterns, plus one long hold-off
    initial begin
        int       win_left;
        int       tick;
        t_rx_mode rx_mode;
        win_left = 0;
        tick     = 0;
        rx_mode  = RX_FREE;
        m_tready = 1'b0;
        forever begin
            if (hold_ask) begin
                m_tready <= 1'b0;
                hold_ask = 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                if (win_left == 0) begin
                    win_left = $urandom_range(16, 96);
                    rx_mode  = t_rx_mode'($urandom_range(0, 3));
                end
                win_left--;
                tick++;
                case (rx_mode)
                    RX_FREE:   m_tready <= 1'b1;
                    RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
                    RX_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
                    default:   m_tready <= (tick % 3 != 0);
                endcase
                @(posedge i_clk);
            end
        end
    end

    // Stimulus
    initial begin
        int                     n;
        int                     phase_left;
        int                     enq_pct;
        int                     focus;
        logic                   cmd;
        logic [LEVEL_W-1:0]     lvl;
        logic [HANDLE_BITS-1:0] handle;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        i_rst_n  = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty dequeue with stray level and handle bits, then a null handle
        send_request(CMD_DEQ, 2'd3, 16'hFFFF);
        send_request(CMD_ENQ, 2'd2, 16'h0000);
        // extremes of handle and level, served highest level first
        send_request(CMD_ENQ, 2'd0, 16'hFFFF);
        send_request(CMD_ENQ, 2'd3, 16'h0001);
        send_request(CMD_ENQ, 2'd2, 16'h8000);
        send_request(CMD_DEQ, 2'd0, 16'h0000);
        send_request(CMD_DEQ, 2'd0, 16'h0000);
        send_request(CMD_DEQ, 2'd0, 16'h0000);
        send_request(CMD_DEQ, 2'd1, 16'h1234);
        // fill one level to capacity, then one more is dropped
        for (n = 0; n <= QUEUE_DEPTH_DEF; n++)
            send_request(CMD_ENQ, 2'd1, HANDLE_BITS'(16'h7FF0 + n));
        wait_all_results();

        // random phases biased towards filling or draining, on one level or all
        phase_left = 0;
        enq_pct    = 50;
        focus      = LEVELS_DEF;
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            if (phase_left == 0) begin
                phase_left = $urandom_range(20, 80);
                case ($urandom_range(0, 4))
                    0:       enq_pct = 90;
                    1:       enq_pct = 65;
                    2:       enq_pct = 50;
                    3:       enq_pct = 35;
                    default: enq_pct = 10;
                endcase
                focus = $urandom_range(0, LEVELS_DEF);
            end
            phase_left--;
            if (n == 300)
                hold_ask = 1'b1;
            if (n == 700)
                wait_all_results();
            cmd = ($urandom_range(0, 99) < enq_pct) ? CMD_ENQ : CMD_DEQ;
            if (focus == LEVELS_DEF || $urandom_range(0, 3) == 0)
                lvl = LEVEL_W'($urandom_range(0, 3));
            else
                lvl = LEVEL_W'(focus);
            handle = ($urandom_range(0, 19) == 0) ? '0 : HANDLE_BITS'($urandom_range(1, 65535));
            send_request(cmd, lvl, handle);
        end

        wait_all_results();
        // catch any stray result after the last one expected
        repeat (8) @(posedge i_clk);
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

@@ sim.f @@
hdl/sptq_pkg.sv
hdl/sptq_ram.sv
hdl/sptq_ctrl.sv
hdl/strict_priority_task_queues.sv
dv/sptq_checker.sv
dv/strict_priority_task_queues_tb.sv
